/* rtl/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [10:0] SIZE_LINE_LIMIT    = 11'd64;
    localparam logic [10:0] TRAILER_LINE_LIMIT = 11'd1024;
    localparam logic [10:0] TERMINATOR_LIMIT   = 11'd8;

    localparam logic [3:0]  DIGITS_MAX = 4'd8;
    localparam logic [3:0]  DIGITS_BAD = 4'd15;

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    localparam logic [7:0]  CHAR_LF   = 8'h0A;
    localparam logic [7:0]  CHAR_CR   = 8'h0D;
    localparam logic [7:0]  CHAR_SEMI = 8'h3B;

    typedef enum logic [4:0] {
        PH_SIZE    = 5'b00001,
        PH_DATA    = 5'b00010,
        PH_TERM    = 5'b00100,
        PH_TRAILER = 5'b01000,
        PH_HALT    = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY    = 3'd0,
        ST_DONE    = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_OVER    = 3'd3,
        ST_LONG    = 3'd4
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] chunk_remaining;
        logic [3:0]  digit_count;
        logic        after_digits_blank;
        logic        in_extension;
        logic [10:0] line_length;
        logic [31:0] body_total;
        logic        last_was_cr;
        status_t     status;
    } parse_state_t;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        status_t     parse_status;
    } result_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:              PH_SIZE,
        chunk_remaining:    32'd0,
        digit_count:        4'd0,
        after_digits_blank: 1'b0,
        in_extension:       1'b0,
        line_length:        11'd0,
        body_total:         32'd0,
        last_was_cr:        1'b0,
        status:             ST_BUSY
    };

    function automatic logic is_blank(input logic [7:0] c);
        logic r;
        r = (c inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C});
        return r;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* rtl/hcbd_parse.sv */
// ----------------------------------------------------------------------------
// hcbd_parse
// Per-byte next-state and result logic of the chunked body decoder.
// ----------------------------------------------------------------------------
module hcbd_parse
(
    input  hcbd_pkg::parse_state_t state_cur,
    input  logic [7:0]             data_byte,
    input  logic                   start_req,
    input  logic [31:0]            max_body_bytes,
    output hcbd_pkg::parse_state_t state_nxt,
    output hcbd_pkg::result_t      result
);

    hcbd_pkg::parse_state_t cur;
    hcbd_pkg::parse_state_t nxt;
    logic [10:0]            limit;
    logic [32:0]            body_sum;
    logic [4:0]             hex;
    logic                   body_valid;
    logic [7:0]             body_byte;

    assign cur      = start_req ? hcbd_pkg::STATE_CLEAR : state_cur;
    assign body_sum = {1'b0, cur.body_total} + {1'b0, cur.chunk_remaining};
    assign hex      = hcbd_pkg::hex_digit(data_byte);

    always_comb
    begin
        nxt        = cur;
        body_valid = 1'b0;
        body_byte  = 8'd0;
        limit      = hcbd_pkg::TRAILER_LINE_LIMIT;

        if (cur.status == hcbd_pkg::ST_BUSY)
        begin
            if (cur.phase == hcbd_pkg::PH_DATA)
            begin
                body_valid          = 1'b1;
                body_byte           = data_byte;
                nxt.chunk_remaining = cur.chunk_remaining - 32'd1;
                if (cur.chunk_remaining == 32'd1)
                begin
                    nxt.line_length        = 11'd0;
                    nxt.last_was_cr        = 1'b0;
                    nxt.digit_count        = 4'd0;
                    nxt.after_digits_blank = 1'b0;
                    nxt.in_extension       = 1'b0;
                    nxt.phase              = hcbd_pkg::PH_TERM;
                end
            end
            else
            begin
                if (cur.phase == hcbd_pkg::PH_SIZE)
                begin
                    limit = hcbd_pkg::SIZE_LINE_LIMIT;
                end
                else if (cur.phase == hcbd_pkg::PH_TERM)
                begin
                    limit = hcbd_pkg::TERMINATOR_LIMIT;
                end

                if (data_byte == hcbd_pkg::CHAR_LF)
                begin
                    nxt.line_length        = 11'd0;
                    nxt.last_was_cr        = 1'b0;
                    nxt.digit_count        = 4'd0;
                    nxt.after_digits_blank = 1'b0;
                    nxt.in_extension       = 1'b0;
                    case (cur.phase)
                        hcbd_pkg::PH_SIZE:
                        begin
                            if (cur.digit_count == 4'd0 ||
                                cur.digit_count == hcbd_pkg::DIGITS_BAD)
                            begin
                                nxt        = cur;
                                nxt.status = hcbd_pkg::ST_BADSIZE;
                                nxt.phase  = hcbd_pkg::PH_HALT;
                            end
                            else if (cur.chunk_remaining == 32'd0)
                            begin
                                nxt.phase = hcbd_pkg::PH_TRAILER;
                            end
                            else if (body_sum > {1'b0, max_body_bytes})
                            begin
                                nxt        = cur;
                                nxt.status = hcbd_pkg::ST_OVER;
                                nxt.phase  = hcbd_pkg::PH_HALT;
                            end
                            else
                            begin
                                nxt.body_total = body_sum[31:0];
                                nxt.phase      = hcbd_pkg::PH_DATA;
                            end
                        end
                        hcbd_pkg::PH_TERM:
                        begin
                            nxt.chunk_remaining = 32'd0;
                            nxt.phase           = hcbd_pkg::PH_SIZE;
                        end
                        default:
                        begin
                            if (cur.line_length == 11'd0 ||
                                (cur.line_length == 11'd1 && cur.last_was_cr))
                            begin
                                nxt.status = hcbd_pkg::ST_DONE;
                                nxt.phase  = hcbd_pkg::PH_HALT;
                            end
                        end
                    endcase
                end
                else if (cur.line_length >= limit)
                begin
                    nxt.status = hcbd_pkg::ST_LONG;
                    nxt.phase  = hcbd_pkg::PH_HALT;
                end
                else
                begin
                    nxt.line_length = cur.line_length + 11'd1;
                    nxt.last_was_cr = (data_byte == hcbd_pkg::CHAR_CR);
                    if (cur.phase == hcbd_pkg::PH_SIZE && !cur.in_extension &&
                        cur.digit_count != hcbd_pkg::DIGITS_BAD)
                    begin
                        if (data_byte == hcbd_pkg::CHAR_SEMI)
                        begin
                            nxt.in_extension = 1'b1;
                        end
                        else if (hcbd_pkg::is_blank(data_byte))
                        begin
                            if (cur.digit_count != 4'd0)
                            begin
                                nxt.after_digits_blank = 1'b1;
                            end
                        end
                        else if (!hex[4] || cur.after_digits_blank ||
                                 cur.digit_count >= hcbd_pkg::DIGITS_MAX)
                        begin
                            nxt.digit_count = hcbd_pkg::DIGITS_BAD;
                        end
                        else
                        begin
                            nxt.chunk_remaining = {cur.chunk_remaining[27:0], hex[3:0]};
                            nxt.digit_count     = cur.digit_count + 4'd1;
                        end
                    end
                end
            end
        end
    end

    assign state_nxt           = nxt;
    assign result.body_valid   = body_valid;
    assign result.body_byte    = body_byte;
    assign result.parse_status = nxt.status;

endmodule

/* rtl/http_chunked_body_decoder_unit.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_unit
// Decodes an HTTP/1.1 chunked body, one byte per transfer.
//
//   channel   dir  payload
//   s_axis    in   tdata: data_byte; tuser: start_req
//   m_axis    out  tdata: body_byte, parse_status; tuser: body_valid
//   cfg       in   cfg_data: max_body_bytes
//
// One byte per cycle sustained while the output is not stalled; each byte
// taken passes the input register, then the result register.
// The parser state update is a single combinational pass per byte.
// Reset sets max_body_bytes to 1048576 and the parser to a fresh body.
// A stalled output holds its result while one more byte waits in the
// input register.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_req

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] body_byte, [10:8] parse_status
    output logic [0:0]  m_axis_tuser,   // [0] body_valid

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    hcbd_pkg::result_t      out_result_reg;
    hcbd_pkg::parse_state_t state_reg;
    hcbd_pkg::parse_state_t state_next;
    hcbd_pkg::result_t      result_next;
    logic [31:0]            max_body_reg;
    logic                   s_fire;
    logic                   advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    hcbd_parse u_parse
    (
        .state_cur      (state_reg),
        .data_byte      (in_byte_reg),
        .start_req      (in_start_reg),
        .max_body_bytes (max_body_reg),
        .state_nxt      (state_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= hcbd_pkg::STATE_CLEAR;
            max_body_reg  <= hcbd_pkg::MAX_BODY_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid)
            begin
                max_body_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_result_reg.parse_status, out_result_reg.body_byte};
    assign m_axis_tuser  = out_result_reg.body_valid;

`ifndef NO_ASSERTIONS
    a_status_halts: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status != hcbd_pkg::ST_BUSY |-> state_reg.phase == hcbd_pkg::PH_HALT)
        else $error("nonzero status outside halt phase");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == hcbd_pkg::PH_DATA |-> state_reg.chunk_remaining != 32'd0)
        else $error("data phase with empty chunk");

    a_body_busy: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.body_valid |-> result_next.parse_status == hcbd_pkg::ST_BUSY)
        else $error("payload byte with final status");
`endif

endmodule

/* tb/tb_http_chunked_body_decoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder_unit
// Self-checking bench for the chunked body decoder. Chunked bodies with
// random content are built, some of them with a malformed size line, an
// over-long line, a cut-off or pure noise. They are streamed in byte by byte
// under several idle patterns and body limits. A behavioral decoder in the
// bench predicts every output transfer, and each one is compared field by field.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import hcbd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_LEN       = 300;
    localparam int SETTLE_CYCLES  = 6;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } stream_byte_t;

    typedef enum int {
        FL_NONE,
        FL_BAD_CHAR,
        FL_GAP_DIGIT,
        FL_NINE_DIGITS,
        FL_NO_DIGIT,
        FL_SIZE_LONG,
        FL_SIZE_FULL,
        FL_TERM_LONG,
        FL_TERM_FULL,
        FL_CUT,
        FL_NOISE
    } flaw_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] data_byte
    logic [0:0]  s_axis_tuser = 1'b0;      // [0] start_req

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] body_byte, [10:8] parse_status
    logic [0:0]  m_axis_tuser;             // [0] body_valid

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'h0;

    stream_byte_t bytes_to_send[$];
    result_t      expected_decoded[$];
    logic [7:0]   frame_q[$];

    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    logic         hold_req = 1'b0;
    logic         hold_ack;
    int           hold_cycles;
    int           mismatches = 0;
    result_t      want;

    phase_t       dec_phase;
    logic [31:0]  dec_remaining;
    logic [3:0]   dec_digits;
    logic         dec_gap;
    logic         dec_ext;
    logic [10:0]  dec_line_len;
    logic [32:0]  dec_total;
    logic         dec_cr;
    status_t      dec_status;
    logic [31:0]  dec_max;

    http_chunked_body_decoder_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == CHAR_CR || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void start_line();
        dec_line_len = 11'd0;
        dec_cr       = 1'b0;
        dec_digits   = 4'd0;
        dec_gap      = 1'b0;
        dec_ext      = 1'b0;
    endfunction

    function automatic void clear_decoder();
        start_line();
        dec_phase     = PH_SIZE;
        dec_remaining = 32'd0;
        dec_total     = 33'd0;
        dec_status    = ST_BUSY;
    endfunction

    function automatic void halt_with(input status_t code);
        dec_status = code;
        dec_phase  = PH_HALT;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] c, input logic restart);
        result_t     r;
        logic [10:0] limit;
        int          hv;
        r.body_valid = 1'b0;
        r.body_byte  = 8'h00;
        if (restart)
            clear_decoder();
        if (dec_status == ST_BUSY)
        begin
            if (dec_phase == PH_DATA)
            begin
                r.body_valid  = 1'b1;
                r.body_byte   = c;
                dec_remaining = dec_remaining - 32'd1;
                if (dec_remaining == 32'd0)
                begin
                    start_line();
                    dec_phase = PH_TERM;
                end
            end
            else
            begin
                limit = (dec_phase == PH_SIZE) ? SIZE_LINE_LIMIT
                      : (dec_phase == PH_TERM) ? TERMINATOR_LIMIT : TRAILER_LINE_LIMIT;
                if (c == CHAR_LF)
                begin
                    if (dec_phase == PH_SIZE)
                    begin
                        if (dec_digits == 4'd0 || dec_digits == DIGITS_BAD)
                            halt_with(ST_BADSIZE);
                        else if (dec_remaining == 32'd0)
                        begin
                            start_line();
                            dec_phase = PH_TRAILER;
                        end
                        else if (dec_total + dec_remaining > {1'b0, dec_max})
                            halt_with(ST_OVER);
                        else
                        begin
                            dec_total = dec_total + dec_remaining;
                            start_line();
                            dec_phase = PH_DATA;
                        end
                    end
                    else if (dec_phase == PH_TERM)
                    begin
                        start_line();
                        dec_remaining = 32'd0;
                        dec_phase     = PH_SIZE;
                    end
                    else
                    begin
                        if (dec_line_len == 11'd0 || (dec_line_len == 11'd1 && dec_cr))
                            halt_with(ST_DONE);
                        start_line();
                    end
                end
                else if (dec_line_len >= limit)
                    halt_with(ST_LONG);
                else
                begin
                    dec_line_len = dec_line_len + 11'd1;
                    dec_cr       = (c == CHAR_CR);
                    if (dec_phase == PH_SIZE && !dec_ext && dec_digits != DIGITS_BAD)
                    begin
                        hv = hex_val(c);
                        if (c == CHAR_SEMI)
                            dec_ext = 1'b1;
                        else if (is_ws(c))
                        begin
                            if (dec_digits != 4'd0)
                                dec_gap = 1'b1;
                        end
                        else if (hv < 0 || dec_gap || dec_digits >= DIGITS_MAX)
                            dec_digits = DIGITS_BAD;
                        else
                        begin
                            dec_remaining = {dec_remaining[27:0], hv[3:0]};
                            dec_digits    = dec_digits + 4'd1;
                        end
                    end
                end
            end
        end
        r.parse_status = dec_status;
        return r;
    endfunction

    // stream generation

    function automatic void put(input logic [7:0] c);
        frame_q.insert(frame_q.size(), c);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_LF);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return 8'h20;
            1: return 8'h09;
            2: return CHAR_CR;
            3: return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void put_eol();
        if ($urandom_range(0, 3) != 0)
            put(CHAR_CR);
        put(CHAR_LF);
    endfunction

    function automatic void put_size_line(input logic [31:0] sz, input flaw_t fl);
        int         ndig;
        int         line_start;
        int         target;
        logic [7:0] c;
        line_start = frame_q.size();
        ndig = 1;
        for (int k = 1; k < 8; k++)
            if ((sz >> (4 * k)) != 0)
                ndig = k + 1;
        if ($urandom_range(0, 3) == 0)
            ndig = $urandom_range(ndig, 8);
        if (fl == FL_NINE_DIGITS)
            ndig = 9;
        repeat ($urandom_range(0, 2))
            put(pick_blank());
        if (fl != FL_NO_DIGIT)
            for (int k = ndig - 1; k >= 0; k--)
                put(hex_char(k < 8 ? sz[4 * k +: 4] : 4'd0));
        if (fl == FL_GAP_DIGIT)
        begin
            put(pick_blank());
            put(hex_char(4'($urandom_range(0, 15))));
        end
        else if (fl == FL_BAD_CHAR)
        begin
            do
                c = rand_text_byte();
            while (hex_val(c) >= 0 || is_ws(c) || c == CHAR_SEMI);
            put(c);
        end
        repeat ($urandom_range(0, 2))
            put(pick_blank());
        if (fl == FL_SIZE_LONG || fl == FL_SIZE_FULL)
        begin
            target = (fl == FL_SIZE_FULL) ? int'(SIZE_LINE_LIMIT)
                                          : int'(SIZE_LINE_LIMIT) + 1 + $urandom_range(0, 3);
            put(CHAR_SEMI);
            while (frame_q.size() - line_start < target - 1)
                put(rand_text_byte());
            put(CHAR_CR);
            put(CHAR_LF);
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                put(CHAR_SEMI);
                repeat ($urandom_range(0, 6))
                    put(rand_text_byte());
            end
            put_eol();
        end
    endfunction

    function automatic void put_term(input flaw_t fl);
        case (fl)
            FL_TERM_LONG:
            begin
                repeat (int'(TERMINATOR_LIMIT) + 1 + $urandom_range(0, 2))
                    put(rand_text_byte());
                put(CHAR_LF);
            end
            FL_TERM_FULL:
            begin
                repeat (int'(TERMINATOR_LIMIT))
                    put(rand_text_byte());
                put(CHAR_LF);
            end
            default:
            begin
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3))
                        put(rand_text_byte());
                put_eol();
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return $urandom_range(1, 12);
            7: return $urandom_range(13, 48);
            8: return $urandom() | 32'h1;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void put_body(input flaw_t fl, input int trailer_len);
        int          nchunks;
        int          flaw_at;
        logic [31:0] sz;
        if (fl == FL_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                put(8'($urandom_range(0, 255)));
            return;
        end
        nchunks = (trailer_len > 0) ? 0 : $urandom_range(0, 3);
        flaw_at = $urandom_range(0, nchunks);
        for (int i = 0; i <= nchunks; i++)
        begin
            sz = (i == nchunks) ? 32'd0 : pick_size();
            put_size_line(sz, (i == flaw_at) ? fl : FL_NONE);
            if (i == nchunks)
                break;
            if (sz > 32'd48)
            begin
                // huge chunk: send a few bytes, next start abandons it
                repeat ($urandom_range(1, 16))
                    put(8'($urandom_range(0, 255)));
                return;
            end
            repeat (sz)
                put(8'($urandom_range(0, 255)));
            put_term((i == flaw_at) ? fl : FL_NONE);
        end
        if (trailer_len > 0)
        begin
            repeat (trailer_len)
                put(rand_text_byte());
            put(CHAR_LF);
        end
        else
            repeat ($urandom_range(0, 2))
            begin
                repeat ($urandom_range(1, 12))
                    put(rand_text_byte());
                put_eol();
            end
        put_eol();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                put(8'($urandom_range(0, 255)));
    endfunction

    function automatic void send_frame(input logic first_start);
        foreach (frame_q[i])
            bytes_to_send.insert(bytes_to_send.size(),
                stream_byte_t'{start: (i == 0) ? first_start : 1'b0, data: frame_q[i]});
        frame_q.delete();
    endfunction

    task automatic fill_phase(input int n);
        int    made;
        flaw_t fl;
        made = 0;
        while (made < n)
        begin
            case ($urandom_range(0, 23))
                0: fl = FL_BAD_CHAR;
                1: fl = FL_GAP_DIGIT;
                2: fl = FL_NINE_DIGITS;
                3: fl = FL_NO_DIGIT;
                4: fl = FL_SIZE_LONG;
                5: fl = FL_SIZE_FULL;
                6: fl = FL_TERM_LONG;
                7: fl = FL_TERM_FULL;
                8: fl = FL_CUT;
                9: fl = FL_NOISE;
                default: fl = FL_NONE;
            endcase
            put_body(fl, 0);
            if (fl == FL_CUT)
                frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
            made += frame_q.size();
            send_frame($urandom_range(0, 15) != 0);
        end
    endtask

    task automatic settle();
        while (bytes_to_send.size() != 0 || s_axis_tvalid || expected_decoded.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dec_max = value;
        @(negedge clk);
    endtask

    // byte driver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_decoded.insert(expected_decoded.size(),
                                        decode_byte(s_axis_tdata, s_axis_tuser[0]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= bytes_to_send[0].data;
                    s_axis_tuser  <= bytes_to_send[0].start;
                    void'(bytes_to_send.pop_front());
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_ack      <= 1'b0;
            hold_cycles   <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_decoded.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: valid=%0d byte=%02h status=%0d",
                                 m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[10:8]);
                end
                else
                begin
                    want = expected_decoded.pop_front();
                    if (m_axis_tuser[0] !== want.body_valid ||
                        m_axis_tdata[7:0] !== want.body_byte ||
                        m_axis_tdata[10:8] !== want.parse_status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected valid=%0d byte=%02h status=%0d,",
                                      " got valid=%0d byte=%02h status=%0d"},
                                     want.body_valid, want.body_byte, want.parse_status,
                                     m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[10:8]);
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack      <= hold_req;
                hold_cycles   <= HOLD_LEN;
                m_axis_tready <= 1'b0;
            end
            else if (hold_cycles != 0)
            begin
                hold_cycles   <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_http_chunked_body_decoder_unit NOT OK");
        $finish;
    end

    initial
    begin
        clear_decoder();
        dec_max = MAX_BODY_RESET;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-byte chunk, done, sticky byte; bad size; size over default limit
        put_text("1");
        put(CHAR_CR);
        put(CHAR_LF);
        put(8'hFF);
        put(CHAR_CR);
        put(CHAR_LF);
        put_text("0");
        put(CHAR_CR);
        put(CHAR_LF);
        put(CHAR_CR);
        put(CHAR_LF);
        put(8'h00);
        send_frame(1'b1);
        put_text("g");
        put(CHAR_LF);
        send_frame(1'b1);
        put_text("FFFFFFFF");
        put(CHAR_LF);
        send_frame(1'b1);
        settle();

        write_limit(32'hFFFF_FFFF);
        hold_req = ~hold_req;
        fill_phase(180);
        settle();

        write_limit(32'd0);
        tx_idle_pct = 70;
        fill_phase(120);
        settle();

        write_limit(32'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 70;
        fill_phase(120);
        settle();

        write_limit($urandom_range(20, 200));
        tx_idle_pct  = 34;
        rx_stall_pct = 34;
        fill_phase(200);
        settle();

        write_limit($urandom());
        fill_phase(150);
        settle();

        if (mismatches == 0 && expected_decoded.size() == 0)
            $display("tb_http_chunked_body_decoder_unit OK");
        else
            $display("tb_http_chunked_body_decoder_unit NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/hcbd_pkg.sv
rtl/hcbd_parse.sv
rtl/http_chunked_body_decoder_unit.sv
tb/tb_http_chunked_body_decoder_unit.sv
